@@ rtl/esd_pkg.sv @@
// Shared constants and types for the escape sequence decoder.
package esd_pkg;

  // Decoded-result queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Raw characters
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharLowN   = 8'h6E;
  localparam logic [7:0] CharLowB   = 8'h62;
  localparam logic [7:0] CharLowR   = 8'h72;
  localparam logic [7:0] CharLowT   = 8'h74;
  localparam logic [7:0] CharLowF   = 8'h66;
  localparam logic [7:0] CharLowX   = 8'h78;

  // Control codes produced by the letter escapes
  localparam logic [7:0] CodeNewline = 8'h0A;
  localparam logic [7:0] CodeBackspc = 8'h08;
  localparam logic [7:0] CodeReturn  = 8'h0D;
  localparam logic [7:0] CodeTab     = 8'h09;
  localparam logic [7:0] CodeFormFd  = 8'h0C;

  // One queued input outcome: one or two result beats
  typedef struct packed {
    logic       two;
    logic [7:0] data0;
    logic       eos0;
    logic [7:0] data1;
    logic       eos1;
  } esd_entry_t;

endpackage

@@ rtl/escape_sequence_decoder.sv @@
// Escape sequence decoder: raw string bytes in, decoded bytes out.
//
// Input channel: in_valid_i / in_ready_o carry one raw byte per beat. A zero
// byte ends the current string. Output channel: out_valid_o / out_ready_i
// carry one decoded byte per beat, with end_of_string_o marking the
// terminator and run_last_o marking the last beat caused by an input byte.
// Bytes that only advance the escape state (backslash, digits of a run)
// cause no output beat; a digit run broken by any byte but a backslash causes two.
// Each outcome is written by the front decode into the 4-entry queue and
// is then registered by the back end as the output beat.
// Throughput: one input byte per cycle and one output beat per cycle. A
// two-beat outcome always follows at least two bytes that caused no beat,
// so with a ready receiver the queue never fills and in_ready_o stays high.
// When the receiver stalls, the output beat holds and the queue absorbs
// up to 4 more outcomes before the input is held off.
// Reset puts the decoder in plain text mode with the queue empty.
module escape_sequence_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       end_of_string_o,
  output logic       run_last_o
);

  esd_pkg::esd_entry_t       wentry, rentry;
  logic                      push, pop, q_full, q_empty;
  logic [esd_pkg::QCntW-1:0] q_count;

  esd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (wentry)
  );

  esd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .pop_i   (pop),
    .rdata_o (rentry),
    .full_o  (q_full),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  esd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_i         (rentry),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .end_of_string_o (end_of_string_o),
    .run_last_o      (run_last_o)
  );

  // terminator is always the final beat of its input byte
  a_eos_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_string_o |-> run_last_o)
    else $error("terminator beat without run_last");

  a_eos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_string_o |-> out_byte_o == 8'd0)
    else $error("terminator beat with nonzero byte");

  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_count == esd_pkg::QCntW'(esd_pkg::QDepth))
    else $error("input held off while queue has room");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("queue write while full");

endmodule

@@ rtl/esd_front.sv @@
// Front end: accepts raw bytes, runs the escape state machine, queues outcomes.
module esd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                q_full_i,
  output logic                push_o,
  output esd_pkg::esd_entry_t entry_o
);

  localparam logic [2:0] ModeNormal = 3'd0;
  localparam logic [2:0] ModeEsc    = 3'd1;
  localparam logic [2:0] ModeZero   = 3'd2;
  localparam logic [2:0] ModeOct    = 3'd3;
  localparam logic [2:0] ModeHex    = 3'd4;

  logic [2:0] mode_q, mode_d;
  logic [7:0] val_q, val_d;
  logic [1:0] cnt_q, cnt_d;

  logic       accept;
  logic [1:0] n_res;
  logic [7:0] c;

  // plain-text handling of the current byte
  logic       p_emit, p_eos;
  logic [2:0] p_mode;

  // digit run helpers
  logic       is_oct;
  logic [7:0] ov_in, onv, hnv;
  logic [1:0] oc_in, onc, hnc;
  logic [4:0] hx;

  function automatic logic [4:0] hex_val(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch inside {[8'h30:8'h39]}) begin
      r = {1'b1, ch[3:0]};
    end else if (ch inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, 4'(ch[3:0] + 4'd9)};
    end
    return r;
  endfunction

  assign c          = in_byte_i;
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign p_emit = (c != esd_pkg::CharBslash);
  assign p_eos  = (c == 8'd0);
  assign p_mode = p_emit ? ModeNormal : ModeEsc;

  assign is_oct = c inside {[8'h30:8'h37]};
  // after backslash-zero the run starts with value 0 and one digit taken
  assign ov_in  = (mode_q == ModeZero) ? 8'd0 : val_q;
  assign oc_in  = (mode_q == ModeZero) ? 2'd1 : cnt_q;
  assign onv    = {ov_in[4:0], 3'b000} + {5'd0, c[2:0]};
  assign onc    = oc_in + 2'd1;
  assign hx     = hex_val(c);
  assign hnv    = {val_q[3:0], hx[3:0]};
  assign hnc    = cnt_q + 2'd1;

  always_comb begin
    mode_d        = mode_q;
    val_d         = val_q;
    cnt_d         = cnt_q;
    n_res         = 2'd0;
    entry_o.two   = 1'b0;
    entry_o.data0 = c;
    entry_o.eos0  = 1'b0;
    entry_o.data1 = c;
    entry_o.eos1  = p_eos;

    case (mode_q)
      ModeEsc: begin
        mode_d = ModeNormal;
        val_d  = 8'd0;
        cnt_d  = 2'd0;
        n_res  = 2'd1;
        case (c)
          8'd0:                 entry_o.eos0 = 1'b1;
          esd_pkg::CharLowN:    entry_o.data0 = esd_pkg::CodeNewline;
          esd_pkg::CharLowB:    entry_o.data0 = esd_pkg::CodeBackspc;
          esd_pkg::CharLowR:    entry_o.data0 = esd_pkg::CodeReturn;
          esd_pkg::CharLowT:    entry_o.data0 = esd_pkg::CodeTab;
          esd_pkg::CharLowF:    entry_o.data0 = esd_pkg::CodeFormFd;
          esd_pkg::CharZero: begin
            mode_d = ModeZero;
            val_d  = val_q;
            cnt_d  = cnt_q;
            n_res  = 2'd0;
          end
          esd_pkg::CharLowX: begin
            mode_d = ModeHex;
            n_res  = 2'd0;
          end
          default: begin
            if (is_oct) begin
              mode_d = ModeOct;
              val_d  = {5'd0, c[2:0]};
              cnt_d  = 2'd1;
              n_res  = 2'd0;
            end
          end
        endcase
      end

      ModeZero, ModeOct: begin
        if (mode_q == ModeZero && c == esd_pkg::CharLowX) begin
          mode_d = ModeHex;
          val_d  = 8'd0;
          cnt_d  = 2'd0;
        end else if (is_oct) begin
          if (onc == 2'd3) begin
            n_res         = 2'd1;
            entry_o.data0 = onv;
            mode_d        = ModeNormal;
            val_d         = 8'd0;
            cnt_d         = 2'd0;
          end else begin
            mode_d = ModeOct;
            val_d  = onv;
            cnt_d  = onc;
          end
        end else begin
          // non-digit ends the run: flush value, then treat byte as text
          entry_o.data0 = ov_in;
          entry_o.two   = p_emit;
          n_res         = p_emit ? 2'd2 : 2'd1;
          mode_d        = p_mode;
          val_d         = 8'd0;
          cnt_d         = 2'd0;
        end
      end

      ModeHex: begin
        if (hx[4]) begin
          if (hnc >= 2'd2) begin
            n_res         = 2'd1;
            entry_o.data0 = hnv;
            mode_d        = ModeNormal;
            val_d         = 8'd0;
            cnt_d         = 2'd0;
          end else begin
            val_d = hnv;
            cnt_d = hnc;
          end
        end else begin
          entry_o.data0 = val_q;
          entry_o.two   = p_emit;
          n_res         = p_emit ? 2'd2 : 2'd1;
          mode_d        = p_mode;
          val_d         = 8'd0;
          cnt_d         = 2'd0;
        end
      end

      default: begin
        mode_d       = p_mode;
        val_d        = 8'd0;
        cnt_d        = 2'd0;
        n_res        = p_emit ? 2'd1 : 2'd0;
        entry_o.eos0 = p_eos;
      end
    endcase
  end

  assign push_o = accept && (n_res != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      val_q  <= 8'd0;
      cnt_q  <= 2'd0;
    end else if (accept) begin
      mode_q <= mode_d;
      val_q  <= val_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ rtl/esd_fifo.sv @@
// Small queue of decoded outcomes between the front and back ends.
module esd_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  esd_pkg::esd_entry_t        wdata_i,
  input  logic                       pop_i,
  output esd_pkg::esd_entry_t        rdata_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [esd_pkg::QCntW-1:0]  count_o
);

  localparam logic [esd_pkg::QPtrW-1:0] LastIdx = esd_pkg::QPtrW'(esd_pkg::QDepth - 1);

  esd_pkg::esd_entry_t mem_q [esd_pkg::QDepth];

  logic [esd_pkg::QPtrW-1:0] wptr_q, rptr_q;
  logic [esd_pkg::QCntW-1:0] cnt_q;
  logic                      do_push, do_pop;

  assign full_o  = (cnt_q == esd_pkg::QCntW'(esd_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/esd_back.sv @@
// Back end: drains queued outcomes into a registered output, one beat per cycle while the receiver is ready.
module esd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  esd_pkg::esd_entry_t entry_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                end_of_string_o,
  output logic                run_last_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       eos_q, last_q;
  logic       second_q;  // first beat of a two-beat entry already sent
  logic       load, take;

  assign load  = !valid_q || out_ready_i;
  assign take  = load && !empty_i;
  assign pop_o = take && (second_q || !entry_i.two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (take) begin
        second_q <= entry_i.two && !second_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= second_q ? entry_i.data1 : entry_i.data0;
      eos_q  <= second_q ? entry_i.eos1 : entry_i.eos0;
      last_q <= second_q || !entry_i.two;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = data_q;
  assign end_of_string_o = eos_q;
  assign run_last_o      = last_q;

endmodule
